[hdl/hbcd_pkg.sv]
// Package for the hashed block cache directory.
// Holds sizes, codes, request and result types, and the controller command struct.
// Depends on nothing; every other file of the block uses it.
package hbcd_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int NUM_BUCKETS = 13;

    localparam int ENTRY_W   = $clog2(NUM_ENTRIES);
    localparam int BUCKET_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CNT_W     = (ENTRY_W > 3) ? ENTRY_W : 3;
    localparam int DIGIT_W   = 4;
    localparam int MOD_STEPS = 32 / DIGIT_W;
    localparam int MOD_IDX_W = $clog2(MOD_STEPS);

    typedef logic [ENTRY_W-1:0]  entry_idx_t;
    typedef logic [BUCKET_W-1:0] bucket_t;
    typedef logic [BUCKET_W:0]   bucket_ext_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [DIGIT_W-1:0]  digit_t;
    typedef logic [4:0]          entry_out_t;
    typedef logic [7:0]          refcnt_t;

    localparam refcnt_t REF_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_GET_COMMIT,
        S_ENTRY_OP
    } state_t;

    typedef struct packed {
        op_t         operation;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  entry_in;
        logic [31:0] now_tick;
    } request_t;

    typedef struct packed {
        entry_out_t entry_out;
        logic       hit;
        logic       needs_read;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic scan_step;
        logic get_commit;
        logic entry_commit;
        cnt_t step;
    } dp_cmd_t;

    // One remainder digit step: folds DIGIT_W more bits, MSB first, into r mod NUM_BUCKETS.
    function automatic bucket_t mod_digit(bucket_t r, digit_t digit);
        bucket_ext_t v;
        bucket_t     acc;
        acc = r;
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            v = {acc, digit[i]};
            if (v >= bucket_ext_t'(NUM_BUCKETS)) begin
                v = v - bucket_ext_t'(NUM_BUCKETS);
            end
            acc = v[BUCKET_W-1:0];
        end
        return acc;
    endfunction

endpackage

[hdl/hbcd_ctrl.sv]
// Controller state machine for the hashed block cache directory.
// Depends on hbcd_pkg; drives the datapath through hbcd_pkg::dp_cmd_t.
module hbcd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  hbcd_pkg::op_t      operation,
    output logic               busy,
    output hbcd_pkg::dp_cmd_t  cmd
);

    hbcd_pkg::state_t state_reg, state_next;
    hbcd_pkg::cnt_t   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hbcd_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.step   = cnt_reg;
        busy       = 1'b1;
        case (state_reg)
            hbcd_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (operation == hbcd_pkg::OP_GET)
                    begin
                        state_next = hbcd_pkg::S_MOD;
                    end
                    else
                    begin
                        state_next = hbcd_pkg::S_ENTRY_OP;
                    end
                end
            end
            hbcd_pkg::S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (cnt_reg == hbcd_pkg::cnt_t'(hbcd_pkg::MOD_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = hbcd_pkg::S_SCAN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            hbcd_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (cnt_reg == hbcd_pkg::cnt_t'(hbcd_pkg::NUM_ENTRIES - 1))
                begin
                    cnt_next   = '0;
                    state_next = hbcd_pkg::S_GET_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            hbcd_pkg::S_GET_COMMIT:
            begin
                cmd.get_commit = 1'b1;
                state_next     = hbcd_pkg::S_IDLE;
            end
            hbcd_pkg::S_ENTRY_OP:
            begin
                cmd.entry_commit = 1'b1;
                state_next       = hbcd_pkg::S_IDLE;
            end
            default:
            begin
                state_next = hbcd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hdl/hbcd_datapath.sv]
// Datapath of the hashed block cache directory: entry table, hash remainder,
// tag and victim scan, and the result register. Depends on hbcd_pkg.
module hbcd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  hbcd_pkg::request_t request,
    input  hbcd_pkg::dp_cmd_t  cmd,
    output hbcd_pkg::result_t  result,
    output logic               done
);

    // Entry table.
    logic                  assigned_reg  [hbcd_pkg::NUM_ENTRIES];
    logic [7:0]            dev_tag_reg   [hbcd_pkg::NUM_ENTRIES];
    logic [31:0]           blk_tag_reg   [hbcd_pkg::NUM_ENTRIES];
    logic                  valid_reg     [hbcd_pkg::NUM_ENTRIES];
    hbcd_pkg::refcnt_t     ref_count_reg [hbcd_pkg::NUM_ENTRIES];
    logic [31:0]           last_use_reg  [hbcd_pkg::NUM_ENTRIES];
    hbcd_pkg::bucket_t     bucket_reg    [hbcd_pkg::NUM_ENTRIES];

    hbcd_pkg::request_t    req_reg;
    hbcd_pkg::bucket_t     home_reg;
    logic                  hit_found_reg;
    hbcd_pkg::entry_idx_t  hit_idx_reg;
    logic                  vic_found_reg;
    hbcd_pkg::entry_idx_t  vic_idx_reg;
    hbcd_pkg::bucket_t     vic_dist_reg;
    logic [31:0]           vic_lu_reg;
    hbcd_pkg::result_t     result_reg, result_next;
    logic                  done_reg;

    hbcd_pkg::entry_idx_t  tgt_idx;
    hbcd_pkg::entry_idx_t  rd_idx;
    logic                  rd_assigned;
    logic [7:0]            rd_dev;
    logic [31:0]           rd_blk;
    logic                  rd_valid;
    hbcd_pkg::refcnt_t     rd_rc;
    logic [31:0]           rd_lu;
    hbcd_pkg::bucket_t     rd_bucket;

    logic                  wr_en;
    logic                  wr_assigned;
    logic [7:0]            wr_dev;
    logic [31:0]           wr_blk;
    logic                  wr_valid;
    hbcd_pkg::refcnt_t     wr_rc;
    logic [31:0]           wr_lu;
    hbcd_pkg::bucket_t     wr_bucket;

    hbcd_pkg::bucket_ext_t dist_ext;
    hbcd_pkg::bucket_t     ring_dist;
    logic                  tag_match;
    logic                  better;
    logic                  in_range;
    logic [4:0]            digit_shift;
    hbcd_pkg::digit_t      digit;

    // Single read port: the scan index during the scan, the target otherwise.
    always_comb
    begin
        if (req_reg.operation == hbcd_pkg::OP_GET)
        begin
            tgt_idx = hit_found_reg ? hit_idx_reg : vic_idx_reg;
        end
        else
        begin
            tgt_idx = hbcd_pkg::entry_idx_t'(req_reg.entry_in);
        end
        rd_idx = cmd.scan_step ? cmd.step[hbcd_pkg::ENTRY_W-1:0] : tgt_idx;
    end

    assign rd_assigned = assigned_reg[rd_idx];
    assign rd_dev      = dev_tag_reg[rd_idx];
    assign rd_blk      = blk_tag_reg[rd_idx];
    assign rd_valid    = valid_reg[rd_idx];
    assign rd_rc       = ref_count_reg[rd_idx];
    assign rd_lu       = last_use_reg[rd_idx];
    assign rd_bucket   = bucket_reg[rd_idx];

    // Hash digit, most significant nibble first.
    assign digit_shift = {(3'(hbcd_pkg::MOD_STEPS - 1)
                          - cmd.step[hbcd_pkg::MOD_IDX_W-1:0]), 2'b00};
    assign digit = hbcd_pkg::digit_t'(req_reg.block_number >> digit_shift);

    // Circular distance of the scanned entry's bucket from the home bucket.
    always_comb
    begin
        if (rd_bucket >= home_reg)
        begin
            dist_ext = {1'b0, rd_bucket} - {1'b0, home_reg};
        end
        else
        begin
            dist_ext = {1'b0, rd_bucket} + hbcd_pkg::bucket_ext_t'(hbcd_pkg::NUM_BUCKETS)
                       - {1'b0, home_reg};
        end
        ring_dist = dist_ext[hbcd_pkg::BUCKET_W-1:0];
    end

    assign tag_match = rd_assigned && (rd_dev == req_reg.device)
                       && (rd_blk == req_reg.block_number);
    assign better    = !vic_found_reg || (ring_dist < vic_dist_reg)
                       || ((ring_dist == vic_dist_reg) && (rd_lu < vic_lu_reg));
    assign in_range  = 32'(req_reg.entry_in) < 32'(hbcd_pkg::NUM_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_reg      <= '0;
            hit_found_reg <= 1'b0;
            hit_idx_reg   <= '0;
            vic_found_reg <= 1'b0;
            vic_idx_reg   <= '0;
            vic_dist_reg  <= '0;
            vic_lu_reg    <= '0;
        end
        else if (cmd.load)
        begin
            home_reg      <= '0;
            hit_found_reg <= 1'b0;
            vic_found_reg <= 1'b0;
        end
        else if (cmd.mod_step)
        begin
            home_reg <= hbcd_pkg::mod_digit(home_reg, digit);
        end
        else if (cmd.scan_step)
        begin
            if (!hit_found_reg && tag_match)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= rd_idx;
            end
            if ((rd_rc == '0) && better)
            begin
                vic_found_reg <= 1'b1;
                vic_idx_reg   <= rd_idx;
                vic_dist_reg  <= ring_dist;
                vic_lu_reg    <= rd_lu;
            end
        end
    end

    // Commit: new entry record and the result.
    always_comb
    begin
        wr_en       = 1'b0;
        wr_assigned = rd_assigned;
        wr_dev      = rd_dev;
        wr_blk      = rd_blk;
        wr_valid    = rd_valid;
        wr_rc       = rd_rc;
        wr_lu       = rd_lu;
        wr_bucket   = rd_bucket;
        result_next            = '0;
        result_next.entry_out  = hbcd_pkg::entry_out_t'(tgt_idx);
        result_next.status     = hbcd_pkg::STAT_OK;
        if (cmd.get_commit)
        begin
            if (hit_found_reg)
            begin
                result_next.hit = 1'b1;
                if (rd_rc == hbcd_pkg::REF_MAX)
                begin
                    result_next.status = hbcd_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    wr_en                  = 1'b1;
                    wr_rc                  = rd_rc + 1'b1;
                    wr_lu                  = req_reg.now_tick;
                    wr_valid               = 1'b1;
                    result_next.needs_read = !rd_valid;
                end
            end
            else if (vic_found_reg)
            begin
                wr_en                  = 1'b1;
                wr_assigned            = 1'b1;
                wr_dev                 = req_reg.device;
                wr_blk                 = req_reg.block_number;
                wr_valid               = 1'b1;
                wr_rc                  = 8'd1;
                wr_lu                  = req_reg.now_tick;
                wr_bucket              = home_reg;
                result_next.needs_read = 1'b1;
            end
            else
            begin
                result_next.entry_out = '0;
                result_next.status    = hbcd_pkg::STAT_NO_FREE;
            end
        end
        else if (cmd.entry_commit)
        begin
            result_next.entry_out = req_reg.entry_in;
            if (in_range)
            begin
                if (req_reg.operation == hbcd_pkg::OP_PIN)
                begin
                    if (rd_rc == hbcd_pkg::REF_MAX)
                    begin
                        result_next.status = hbcd_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        wr_rc = rd_rc + 1'b1;
                    end
                end
                else if (rd_rc == '0)
                begin
                    result_next.status = hbcd_pkg::STAT_UNDERFLOW;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_rc = rd_rc - 1'b1;
                    if (req_reg.operation == hbcd_pkg::OP_RELEASE)
                    begin
                        wr_lu = req_reg.now_tick;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hbcd_pkg::NUM_ENTRIES; i++)
            begin
                assigned_reg[i]  <= 1'b0;
                valid_reg[i]     <= 1'b0;
                ref_count_reg[i] <= '0;
                last_use_reg[i]  <= '0;
                bucket_reg[i]    <= '0;
            end
        end
        else if (wr_en)
        begin
            assigned_reg[tgt_idx]  <= wr_assigned;
            valid_reg[tgt_idx]     <= wr_valid;
            ref_count_reg[tgt_idx] <= wr_rc;
            last_use_reg[tgt_idx]  <= wr_lu;
            bucket_reg[tgt_idx]    <= wr_bucket;
        end
    end

    // Tags are only looked at while the entry is assigned.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dev_tag_reg[tgt_idx] <= wr_dev;
            blk_tag_reg[tgt_idx] <= wr_blk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.get_commit || cmd.entry_commit)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.get_commit || cmd.entry_commit;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

[hdl/hashed_block_cache_directory_core.sv]
// Top level of the hashed block cache directory.
// Depends on hbcd_pkg, hbcd_ctrl and hbcd_datapath.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low. The request carries the operation (get, release, pin or unpin), the
// device and block number for a get, the entry index for the other three,
// and the current tick used as the recency stamp.
// Every request yields exactly one result, shown on the result port for one
// cycle while done is high. The receiver cannot stall; it must take the
// result in that cycle. A new request may be taken in the same cycle that
// the previous result is shown, since the result sits in its own register.
// Operation: a get first folds the block number into its home bucket, four
// bits per cycle, then scans the entry table one entry per cycle over its
// single read port, looking for a tag match and for the best free victim at
// once, then commits. Done is high in the cycle after the commit. One request
// is handled at a time: the next is taken only once busy has dropped. Release,
// pin and unpin skip the fold and the scan and go straight to their commit.
// Busy is high from acceptance until the result appears.
// Reset clears every entry except its tags at once: all entries unassigned, in
// bucket zero, with zero counts and stamps. The block is ready right after reset.
module hashed_block_cache_directory_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  hbcd_pkg::request_t request,
    output logic               done,
    output hbcd_pkg::result_t  result
);

    hbcd_pkg::dp_cmd_t cmd;

    hbcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .busy      (busy),
        .cmd       (cmd)
    );

    hbcd_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .result  (result),
        .done    (done)
    );

`ifndef SYNTHESIS
    // The block only goes idle by delivering a result.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // A commit state and the done register lie between acceptance and result, so results never come back to back.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("two results in consecutive cycles");

    // An accepted request keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted request did not make the block busy");

    // A missing free buffer reports neither a hit nor a read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == hbcd_pkg::STAT_NO_FREE)
        |-> (!result.hit && !result.needs_read && result.entry_out == '0))
        else $error("no-free result carries stray fields");

    // A read is requested only for a successful grant.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.needs_read) |-> (result.status == hbcd_pkg::STAT_OK))
        else $error("read requested on a failed request");
`endif

endmodule

[tb/hbcd_scoreboard_pkg.sv]
// Scoreboard for the hashed block cache directory testbench.
// Holds a predictor of the directory table and the queue of expected results.
// Depends on hbcd_pkg for sizes, codes and the request and result types.
package hbcd_scoreboard_pkg;

    import hbcd_pkg::*;

    class block_cache_scoreboard;

        bit          is_assigned [NUM_ENTRIES];
        logic [7:0]  dev_tag     [NUM_ENTRIES];
        logic [31:0] blk_tag     [NUM_ENTRIES];
        bit          data_valid  [NUM_ENTRIES];
        refcnt_t     refs        [NUM_ENTRIES];
        logic [31:0] stamp       [NUM_ENTRIES];
        result_t     expected_results [$];
        int          mismatches;

        function new();
            for (int e = 0; e < NUM_ENTRIES; e++)
            begin
                is_assigned[e] = 1'b0;
                dev_tag[e]     = '0;
                blk_tag[e]     = '0;
                data_valid[e]  = 1'b0;
                refs[e]        = '0;
                stamp[e]       = '0;
            end
            mismatches = 0;
        endfunction

        // Applies one request to the table copy and returns the result it yields.
        function result_t apply_request(request_t rq);
            result_t r;
            int      home;
            int      bkt;
            int      ring_dist;
            int      best_dist;
            int      victim;
            int      idx;
            r.entry_out  = '0;
            r.hit        = 1'b0;
            r.needs_read = 1'b0;
            r.status     = STAT_OK;
            if (rq.operation == OP_GET)
            begin
                for (int e = 0; e < NUM_ENTRIES; e++)
                begin
                    if (is_assigned[e] && dev_tag[e] == rq.device &&
                        blk_tag[e] == rq.block_number)
                    begin
                        r.entry_out = entry_out_t'(e);
                        r.hit       = 1'b1;
                        if (refs[e] == REF_MAX)
                        begin
                            r.status = STAT_OVERFLOW;
                            return r;
                        end
                        refs[e]      = refs[e] + 1'b1;
                        stamp[e]     = rq.now_tick;
                        r.needs_read = !data_valid[e];
                        data_valid[e] = 1'b1;
                        return r;
                    end
                end
                // Nearest bucket going round from home, then oldest stamp, then
                // lowest index.
                home      = int'(rq.block_number % NUM_BUCKETS);
                victim    = -1;
                best_dist = NUM_BUCKETS;
                for (int e = 0; e < NUM_ENTRIES; e++)
                begin
                    if (refs[e] == 0)
                    begin
                        bkt       = is_assigned[e] ? int'(blk_tag[e] % NUM_BUCKETS) : 0;
                        ring_dist = (bkt - home + NUM_BUCKETS) % NUM_BUCKETS;
                        if (victim < 0 || ring_dist < best_dist ||
                            (ring_dist == best_dist && stamp[e] < stamp[victim]))
                        begin
                            victim    = e;
                            best_dist = ring_dist;
                        end
                    end
                end
                if (victim < 0)
                begin
                    r.status = STAT_NO_FREE;
                    return r;
                end
                is_assigned[victim] = 1'b1;
                dev_tag[victim]     = rq.device;
                blk_tag[victim]     = rq.block_number;
                data_valid[victim]  = 1'b1;
                refs[victim]        = 8'd1;
                stamp[victim]       = rq.now_tick;
                r.entry_out         = entry_out_t'(victim);
                r.needs_read        = 1'b1;
                return r;
            end
            r.entry_out = rq.entry_in;
            idx = int'(rq.entry_in);
            if (idx >= NUM_ENTRIES)
            begin
                return r;
            end
            if (rq.operation == OP_PIN)
            begin
                if (refs[idx] == REF_MAX)
                begin
                    r.status = STAT_OVERFLOW;
                end
                else
                begin
                    refs[idx] = refs[idx] + 1'b1;
                end
                return r;
            end
            if (refs[idx] == 0)
            begin
                r.status = STAT_UNDERFLOW;
                return r;
            end
            refs[idx] = refs[idx] - 1'b1;
            if (rq.operation == OP_RELEASE)
            begin
                stamp[idx] = rq.now_tick;
            end
            return r;
        endfunction

        function void note_request(request_t rq);
            expected_results.push_back(apply_request(rq));
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got,
                                   realtime at_ns);
            if (got !== want)
            begin
                $display("%0.0f ns: %s expected %0d, actual %0d", at_ns, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got, realtime at_ns);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0.0f ns: result with no request outstanding, expected none, actual %h",
                         at_ns, got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            report_field("entry_out", want.entry_out, got.entry_out, at_ns);
            report_field("hit", want.hit, got.hit, at_ns);
            report_field("needs_read", want.needs_read, got.needs_read, at_ns);
            report_field("status", want.status, got.status, at_ns);
        endfunction

    endclass

endpackage

[tb/tb_hashed_block_cache_directory_core.sv]
// Testbench for hashed_block_cache_directory_core: directed and random requests,
// every result checked field by field against a predictor of the directory.
// Depends on hbcd_pkg and hbcd_scoreboard_pkg.
module tb_hashed_block_cache_directory_core;

    timeunit 1ns;
    timeprecision 1ps;

    import hbcd_pkg::*;
    import hbcd_scoreboard_pkg::*;

    localparam int TARGET_REQUESTS = 1450;
    // A get and the longest sender gap are both far shorter than QUIET_LIMIT, so a
    // quiet stretch of that length can only mean the block has hung.
    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int POOL_SIZE       = 32;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;

    block_cache_scoreboard sb = new();

    // Blocks that gets draw from most of the time, so that hits are common.
    logic [7:0]  pool_dev [POOL_SIZE];
    logic [31:0] pool_blk [POOL_SIZE];
    logic [31:0] tick_now;
    int          sent;
    bit          burst_mode;
    int          quiet_cycles;

    hashed_block_cache_directory_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Results cannot be held off, so every cycle with done high is checked.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(result, $realtime);
        end
    end

    // Counts cycles in which neither a request nor a result is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("hashed_block_cache_directory_core: mismatch");
                $finish;
            end
        end
    end

    // Mostly back to back or short gaps, now and then a long gap that may outlast a get.
    function automatic int pick_gap();
        int roll;
        if (burst_mode)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 90);
    endfunction

    // The tick mostly creeps forward; an occasional jump lands anywhere, so
    // stamps also go backward and across the 32-bit wrap.
    function automatic logic [31:0] next_tick();
        if ($urandom_range(0, 49) == 0)
        begin
            tick_now = $urandom();
        end
        else
        begin
            tick_now = tick_now + $urandom_range(0, 3);
        end
        return tick_now;
    endfunction

    function automatic request_t make_request(op_t op, logic [7:0] dev, logic [31:0] blk,
                                              logic [4:0] ent, logic [31:0] tick);
        request_t rq;
        rq.operation    = op;
        rq.device       = dev;
        rq.block_number = blk;
        rq.entry_in     = ent;
        rq.now_tick     = tick;
        return rq;
    endfunction

    // Picks an entry that currently holds references, so that releases and
    // unpins mostly succeed; any entry when none is held.
    function automatic logic [4:0] held_entry();
        int held [$];
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            if (sb.refs[e] != 0)
            begin
                held.push_back(e);
            end
        end
        if (held.size() == 0)
        begin
            return 5'($urandom_range(0, NUM_ENTRIES - 1));
        end
        return 5'(held[$urandom_range(0, held.size() - 1)]);
    endfunction

    // Fields that the operation ignores carry random values throughout.
    function automatic request_t random_request();
        request_t rq;
        int       roll;
        int       k;
        rq.device       = $urandom();
        rq.block_number = $urandom();
        rq.entry_in     = $urandom();
        rq.now_tick     = next_tick();
        roll = $urandom_range(0, 99);
        if (roll < 40)
        begin
            rq.operation = OP_GET;
            if ($urandom_range(0, 4) != 0)
            begin
                k = $urandom_range(0, POOL_SIZE - 1);
                rq.device       = pool_dev[k];
                rq.block_number = pool_blk[k];
            end
        end
        else
        begin
            if (roll < 48)
            begin
                rq.operation = OP_PIN;
            end
            else if (roll < 80)
            begin
                rq.operation = OP_RELEASE;
            end
            else
            begin
                rq.operation = OP_UNPIN;
            end
            if ($urandom_range(0, 9) != 0)
            begin
                rq.entry_in = held_entry();
            end
        end
        return rq;
    endfunction

    // Called at a falling edge and returns at one. Start stays high between
    // back-to-back requests; the request is taken at the first rising edge
    // that sees busy low.
    task automatic send_request(input request_t rq);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        request = rq;
        start   = 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(rq);
        sent++;
        @(negedge clk);
    endtask

    // Holds the sender off until every result owed has come back.
    task automatic wait_for_results();
        start = 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Pins every free entry so that gets find no free buffer, then hands the
    // references back.
    task automatic exhaust_free_entries();
        int pinned [$];
        int k;
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            if (sb.refs[e] == 0)
            begin
                pinned.push_back(e);
                send_request(make_request(OP_PIN, $urandom(), $urandom(), 5'(e), next_tick()));
            end
        end
        repeat ($urandom_range(1, 3))
        begin
            send_request(make_request(OP_GET, $urandom(), $urandom(), $urandom(), next_tick()));
        end
        // A pool block may still hit while the table is full.
        k = $urandom_range(0, POOL_SIZE - 1);
        send_request(make_request(OP_GET, pool_dev[k], pool_blk[k], $urandom(), next_tick()));
        foreach (pinned[i])
        begin
            send_request(make_request(OP_UNPIN, $urandom(), $urandom(), 5'(pinned[i]),
                                      next_tick()));
        end
    endtask

    // Drives one entry to the top of its count: a pin past it overflows, a get
    // of its block hits at full count, and after draining a release underflows.
    task automatic saturate_one_entry();
        logic [4:0] ent;
        ent = 5'($urandom_range(0, NUM_ENTRIES - 1));
        while (sb.refs[ent] != REF_MAX)
        begin
            send_request(make_request(OP_PIN, $urandom(), $urandom(), ent, next_tick()));
        end
        send_request(make_request(OP_PIN, $urandom(), $urandom(), ent, next_tick()));
        if (sb.is_assigned[ent])
        begin
            send_request(make_request(OP_GET, sb.dev_tag[ent], sb.blk_tag[ent], $urandom(),
                                      next_tick()));
        end
        while (sb.refs[ent] != 0)
        begin
            send_request(make_request($urandom_range(0, 1) ? OP_UNPIN : OP_RELEASE,
                                      $urandom(), $urandom(), ent, next_tick()));
        end
        send_request(make_request(OP_RELEASE, $urandom(), $urandom(), ent, next_tick()));
    endtask

    initial
    begin
        int roll;
        bit saturated;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        tick_now   = '0;
        sent       = 0;
        burst_mode = 1'b0;
        saturated  = 1'b0;

        // Pool: small blocks and blocks that share a bucket, the extremes of
        // the block number, and one block repeated under another device.
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            pool_dev[k] = (k % 3 == 0) ? 8'd0 : 8'($urandom_range(0, 255));
            pool_blk[k] = (k % 2 == 0) ? $urandom_range(0, 64) : $urandom();
        end
        pool_dev[1] = 8'hFF;
        pool_blk[0] = 32'd0;
        pool_blk[1] = 32'hFFFF_FFFF;
        pool_blk[2] = 32'd13;
        pool_blk[3] = 32'd26;
        pool_blk[4] = 32'h8000_0000;
        pool_blk[5] = 32'd12;
        pool_blk[7] = pool_blk[6];

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. At startup every entry is unassigned in bucket zero,
        // so a get of block zero misses and takes entry zero.
        send_request(make_request(OP_GET, 8'd0, 32'd0, 5'd0, 32'd0));
        send_request(make_request(OP_GET, 8'd0, 32'd0, 5'd31, 32'd1));
        send_request(make_request(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF));
        // Same block under two devices must occupy two entries.
        send_request(make_request(OP_GET, 8'hA5, 32'd13, 5'd0, 32'd2));
        send_request(make_request(OP_GET, 8'd0, 32'd13, 5'd0, 32'd3));
        // Count down to zero, then one release too many underflows.
        send_request(make_request(OP_RELEASE, 8'd0, 32'd0, 5'd0, 32'd4));
        send_request(make_request(OP_RELEASE, 8'd0, 32'd0, 5'd0, 32'd5));
        send_request(make_request(OP_RELEASE, 8'd0, 32'd0, 5'd0, 32'd6));
        send_request(make_request(OP_UNPIN, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'd6));
        send_request(make_request(OP_PIN, 8'd0, 32'd0, 5'd31, 32'd6));
        send_request(make_request(OP_PIN, 8'd0, 32'd0, 5'd31, 32'd6));
        send_request(make_request(OP_UNPIN, 8'd0, 32'd0, 5'd31, 32'd6));
        send_request(make_request(OP_RELEASE, 8'd0, 32'd0, 5'd31, 32'd7));
        // A released entry keeps its tags, so the same block hits again.
        send_request(make_request(OP_GET, 8'd0, 32'd0, 5'd0, 32'd8));
        // A stamp of zero makes entry one the oldest of its bucket.
        send_request(make_request(OP_RELEASE, 8'd0, 32'd0, 5'd1, 32'd0));
        send_request(make_request(OP_GET, 8'd7, 32'd26, 5'd0, 32'd9));
        send_request(make_request(OP_GET, 8'd7, 32'd1, 5'd0, 32'd10));
        send_request(make_request(OP_PIN, 8'd0, 32'd0, 5'd0, 32'd11));
        send_request(make_request(OP_UNPIN, 8'd0, 32'd0, 5'd0, 32'd11));
        send_request(make_request(OP_GET, 8'h5A, 32'h8000_0000, 5'd16, 32'h8000_0000));
        send_request(make_request(OP_RELEASE, 8'd0, 32'd0, 5'd2, 32'hFFFF_FFFF));
        send_request(make_request(OP_GET, 8'hA5, 32'd13, 5'd16, 32'd12));
        wait_for_results();
        tick_now = 32'd100;

        // Random part, in episodes: mostly mixed traffic, sometimes a full
        // table, once a saturated count. Some episodes run without gaps, and
        // some end with the sender held off until everything is back.
        while (sent < TARGET_REQUESTS)
        begin
            roll       = $urandom_range(0, 99);
            burst_mode = ($urandom_range(0, 5) == 0);
            if (!saturated && sent > 500)
            begin
                saturate_one_entry();
                saturated = 1'b1;
            end
            else if (roll < 8)
            begin
                exhaust_free_entries();
            end
            else
            begin
                repeat ($urandom_range(20, 60))
                begin
                    send_request(random_request());
                end
            end
            if (roll >= 90)
            begin
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
        begin
            $display("hashed_block_cache_directory_core: match");
        end
        else
        begin
            $display("hashed_block_cache_directory_core: mismatch");
        end
        $finish;
    end

endmodule
